// ===== rtl/core/gdn_pkg.sv =====
package gdn_pkg;

  localparam int FRAC_BITS = 14;
  // quotient width, one pipeline stage per quotient bit
  localparam int QW = FRAC_BITS + 1;
  localparam int NB = FRAC_BITS + 1;
  // prep stage, NB iteration stages, output stage
  localparam int NS = NB + 2;
  // wide accumulators for q*q*s and (q*d+off)^2
  localparam int PW = 2 * FRAC_BITS + 34;
  // trigger remainder width
  localparam int RW = 8 + FRAC_BITS;

  localparam logic [14:0] STICK_FULL    = 15'd32767;
  localparam logic [31:0] STICK_FULL_SQ = 32'd1073676289;
  localparam logic [7:0]  TRIG_FULL     = 8'd255;
  localparam logic [14:0] LVL_SAT       = 15'h7fff;
  localparam logic [14:0] LVL_FULL      = (FRAC_BITS >= 15) ? LVL_SAT : 15'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    CFG_LEFT_DZ  = 2'd0,
    CFG_RIGHT_DZ = 2'd1,
    CFG_TRIG_TH  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic          active;
    logic          clip;
    logic          neg_x;
    logic          neg_y;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic [QW-1:0] qm;
  } stick_res_t;

  typedef struct packed {
    logic          active;
    logic [QW-1:0] q;
  } trig_res_t;

  function automatic logic [14:0] sat_lvl(input logic [QW-1:0] q);
    logic [14:0] r;
    if (q > QW'(32767)) r = LVL_SAT;
    else r = 15'(q);
    return r;
  endfunction

endpackage

// ===== rtl/core/gdn_stick_lane.sv =====
module gdn_stick_lane import gdn_pkg::*; (
  input  logic               clk_i,
  input  logic [NB:0]        load_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic [14:0]        dz_i,
  output stick_res_t         res_o
);

  typedef struct packed {
    logic          neg_x;
    logic          neg_y;
    logic [30:0]   ax2;
    logic [30:0]   ay2;
    logic [31:0]   s;
    logic [29:0]   dz2;
    logic [29:0]   d2;
    logic [QW-1:0] qx;
    logic [PW-1:0] px;
    logic [PW-1:0] qsx;
    logic [QW-1:0] qy;
    logic [PW-1:0] py;
    logic [PW-1:0] qsy;
    logic [QW-1:0] qm;
    logic [PW-1:0] sm;
    logic [PW-1:0] um;
  } stk_st_t;

  stk_st_t st_q [0:NB];

  logic signed [31:0] xx, yy;
  logic [14:0] d_w;
  logic [29:0] dz2_w, d2_w, dzd_w;
  stk_st_t st0_d;

  assign xx    = x_i * x_i;
  assign yy    = y_i * y_i;
  assign d_w   = 15'(STICK_FULL - dz_i);
  assign dz2_w = dz_i * dz_i;
  assign d2_w  = d_w * d_w;
  assign dzd_w = dz_i * d_w;

  always_comb begin
    st0_d       = '0;
    st0_d.neg_x = x_i[15];
    st0_d.neg_y = y_i[15];
    st0_d.ax2   = xx[30:0];
    st0_d.ay2   = yy[30:0];
    st0_d.s     = 32'(xx[30:0]) + 32'(yy[30:0]);
    st0_d.dz2   = dz2_w;
    st0_d.d2    = d2_w;
    // magnitude search starts at t = dz << F
    st0_d.sm    = PW'(dz2_w) << (2 * FRAC_BITS);
    st0_d.um    = PW'(dzd_w) << FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) st_q[0] <= st0_d;
  end

  for (genvar i = 1; i <= NB; i++) begin : g_it
    localparam int B = NB - i;
    stk_st_t nx;
    logic [PW-1:0] px_c, py_c, sm_c, rhs_x, rhs_y, rhs_m;

    always_comb begin
      nx    = st_q[i-1];
      rhs_x = PW'(st_q[i-1].ax2) << (2 * FRAC_BITS);
      rhs_y = PW'(st_q[i-1].ay2) << (2 * FRAC_BITS);
      rhs_m = PW'(st_q[i-1].s) << (2 * FRAC_BITS);
      // (q + 2^b)^2 * s from running q^2*s and q*s
      px_c  = st_q[i-1].px + (st_q[i-1].qsx << (B + 1)) + (PW'(st_q[i-1].s) << (2 * B));
      py_c  = st_q[i-1].py + (st_q[i-1].qsy << (B + 1)) + (PW'(st_q[i-1].s) << (2 * B));
      sm_c  = st_q[i-1].sm + (st_q[i-1].um << (B + 1)) + (PW'(st_q[i-1].d2) << (2 * B));
      if (px_c <= rhs_x) begin
        nx.qx  = st_q[i-1].qx | (QW'(1) << B);
        nx.px  = px_c;
        nx.qsx = st_q[i-1].qsx + (PW'(st_q[i-1].s) << B);
      end
      if (py_c <= rhs_y) begin
        nx.qy  = st_q[i-1].qy | (QW'(1) << B);
        nx.py  = py_c;
        nx.qsy = st_q[i-1].qsy + (PW'(st_q[i-1].s) << B);
      end
      if (sm_c <= rhs_m) begin
        nx.qm = st_q[i-1].qm | (QW'(1) << B);
        nx.sm = sm_c;
        nx.um = st_q[i-1].um + (PW'(st_q[i-1].d2) << B);
      end
    end

    always_ff @(posedge clk_i) begin
      if (load_i[i]) st_q[i] <= nx;
    end
  end

  assign res_o.active = st_q[NB].s > 32'(st_q[NB].dz2);
  assign res_o.clip   = st_q[NB].s >= STICK_FULL_SQ;
  assign res_o.neg_x  = st_q[NB].neg_x;
  assign res_o.neg_y  = st_q[NB].neg_y;
  assign res_o.qx     = st_q[NB].qx;
  assign res_o.qy     = st_q[NB].qy;
  assign res_o.qm     = st_q[NB].qm;

endmodule

// ===== rtl/core/gdn_trig_lane.sv =====
module gdn_trig_lane import gdn_pkg::*; (
  input  logic        clk_i,
  input  logic [NB:0] load_i,
  input  logic [7:0]  raw_i,
  input  logic [7:0]  th_i,
  output trig_res_t   res_o
);

  typedef struct packed {
    logic          active;
    logic [7:0]    den;
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
  } trg_st_t;

  trg_st_t st_q [0:NB];
  trg_st_t st0_d;

  always_comb begin
    st0_d        = '0;
    st0_d.active = raw_i > th_i;
    st0_d.den    = TRIG_FULL - th_i;
    st0_d.rem    = RW'(8'(raw_i - th_i)) << FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) st_q[0] <= st0_d;
  end

  // restoring division, one quotient bit per stage
  for (genvar i = 1; i <= NB; i++) begin : g_it
    localparam int B = NB - i;
    trg_st_t nx;
    logic [RW-1:0] dsh;

    always_comb begin
      nx  = st_q[i-1];
      dsh = RW'(st_q[i-1].den) << B;
      if (st_q[i-1].rem >= dsh) begin
        nx.rem = st_q[i-1].rem - dsh;
        nx.q   = st_q[i-1].q | (QW'(1) << B);
      end
    end

    always_ff @(posedge clk_i) begin
      if (load_i[i]) st_q[i] <= nx;
    end
  end

  assign res_o.active = st_q[NB].active;
  assign res_o.q      = st_q[NB].q;

endmodule

// ===== rtl/core/gamepad_deadzone_normalizer_unit.sv =====
// throughput: one beat per cycle while out_ready_i is high; a 17-stage pipeline:
// a prep stage, one quotient bit per stage over 15 stages in each stick and trigger
// lane, and an output stage, with per-stage valid bits and a ready chain
// reset: pipeline valid bits clear; deadzones go to 7849 / 8689, threshold to 30
// payload registers are not reset
module gamepad_deadzone_normalizer_unit import gdn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] left_x_i,
  input  logic signed [15:0] left_y_i,
  input  logic signed [15:0] right_x_i,
  input  logic signed [15:0] right_y_i,
  input  logic [7:0]         left_trig_raw_i,
  input  logic [7:0]         right_trig_raw_i,
  input  logic [15:0]        raw_buttons_i,
  input  logic [31:0]        packet_number_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] left_dir_x_o,
  output logic signed [15:0] left_dir_y_o,
  output logic [14:0]        left_magnitude_o,
  output logic signed [15:0] right_dir_x_o,
  output logic signed [15:0] right_dir_y_o,
  output logic [14:0]        right_magnitude_o,
  output logic [14:0]        left_trig_level_o,
  output logic [14:0]        right_trig_level_o,
  output logic [19:0]        merged_buttons_o,
  output logic [31:0]        generation_o
);

  logic [14:0] left_dz_q, right_dz_q;
  logic [7:0]  trig_th_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_dz_q  <= 15'd7849;
      right_dz_q <= 15'd8689;
      trig_th_q  <= 8'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LEFT_DZ:  left_dz_q  <= cfg_data_i;
        CFG_RIGHT_DZ: right_dz_q <= cfg_data_i;
        CFG_TRIG_TH:  trig_th_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // valid bits and ready chain, bubbles collapse
  logic [NS-1:0] v_q, v_d, src, load;
  logic [NS:0]   rdy;

  assign rdy[NS] = out_ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_vld
    if (k == 0) begin : g_first
      assign src[k] = in_valid_i;
    end else begin : g_rest
      assign src[k] = v_q[k-1];
    end
    assign rdy[k]  = ~v_q[k] | rdy[k+1];
    assign load[k] = rdy[k] & src[k];
    assign v_d[k]  = rdy[k] ? src[k] : v_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= v_d;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];

  stick_res_t stk_l, stk_r;
  trig_res_t  trg_l, trg_r;

  gdn_stick_lane u_stick_l (
    .clk_i (clk_i), .load_i(load[NB:0]), .x_i(left_x_i), .y_i(left_y_i),
    .dz_i  (left_dz_q), .res_o(stk_l)
  );

  gdn_stick_lane u_stick_r (
    .clk_i (clk_i), .load_i(load[NB:0]), .x_i(right_x_i), .y_i(right_y_i),
    .dz_i  (right_dz_q), .res_o(stk_r)
  );

  gdn_trig_lane u_trig_l (
    .clk_i(clk_i), .load_i(load[NB:0]), .raw_i(left_trig_raw_i), .th_i(trig_th_q),
    .res_o(trg_l)
  );

  gdn_trig_lane u_trig_r (
    .clk_i(clk_i), .load_i(load[NB:0]), .raw_i(right_trig_raw_i), .th_i(trig_th_q),
    .res_o(trg_r)
  );

  logic [15:0] btn_q [0:NB];
  logic [31:0] pkt_q [0:NB];

  for (genvar k = 0; k <= NB; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (load[k]) begin
        if (k == 0) begin
          btn_q[k] <= raw_buttons_i;
          pkt_q[k] <= packet_number_i;
        end else begin
          btn_q[k] <= btn_q[(k == 0) ? 0 : k-1];
          pkt_q[k] <= pkt_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // merge stage
  function automatic logic [15:0] fmt_dir(input logic act, input logic neg,
                                          input logic [QW-1:0] q);
    logic [15:0] m;
    m = 16'(sat_lvl(q));
    if (!act) return 16'd0;
    return neg ? 16'(16'd0 - m) : m;
  endfunction

  function automatic logic [14:0] fmt_mag(input stick_res_t r);
    logic [14:0] m;
    m = r.clip ? LVL_FULL : sat_lvl(r.qm);
    return r.active ? m : 15'd0;
  endfunction

  always_ff @(posedge clk_i) begin
    if (load[NS-1]) begin
      left_dir_x_o       <= fmt_dir(stk_l.active, stk_l.neg_x, stk_l.qx);
      left_dir_y_o       <= fmt_dir(stk_l.active, stk_l.neg_y, stk_l.qy);
      left_magnitude_o   <= fmt_mag(stk_l);
      right_dir_x_o      <= fmt_dir(stk_r.active, stk_r.neg_x, stk_r.qx);
      right_dir_y_o      <= fmt_dir(stk_r.active, stk_r.neg_y, stk_r.qy);
      right_magnitude_o  <= fmt_mag(stk_r);
      left_trig_level_o  <= trg_l.active ? sat_lvl(trg_l.q) : 15'd0;
      right_trig_level_o <= trg_r.active ? sat_lvl(trg_r.q) : 15'd0;
      merged_buttons_o   <= {trg_r.active, trg_l.active, stk_r.active, stk_l.active,
                             btn_q[NB]};
      generation_o       <= pkt_q[NB];
    end
  end

endmodule
